// File: design/scf_pkg.sv
package scf_pkg;

   localparam int WORD_WIDTH    = 32;
   localparam int ACTION_WIDTH  = 2;
   localparam int DEPTH_DEFAULT = 64;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic [ACTION_WIDTH-1:0]      action_type;

   localparam action_type ACT_ENQUEUE = 2'd0;
   localparam action_type ACT_DEQUEUE = 2'd1;
   localparam action_type ACT_SEARCH  = 2'd2;

   localparam word_type EMPTY_WORD = -32'sd1;

   // Broadcast from the top level to every cell of the chain.
   typedef struct packed {
      logic     step;
      logic     enq;
      logic     deq;
      logic     srch;
      word_type data;
   } chain_ctrl_type;

endpackage

// File: design/scf_if.sv
interface scf_req_if
   import scf_pkg::*;
   ();
   logic       valid;
   logic       ready;
   action_type action;
   word_type   data_value;

   modport source (output valid, output action, output data_value, input ready);
   modport sink   (input valid, input action, input data_value, output ready);
endinterface

interface scf_rsp_if
   import scf_pkg::*;
   #(parameter int CNT_W = $clog2(DEPTH_DEFAULT + 1))
   ();
   logic             valid;
   logic             ready;
   logic             ok;
   word_type         popped_value;
   logic             found;
   word_type         head_value;
   word_type         tail_value;
   logic [CNT_W-1:0] entry_count;

   modport source (output valid, output ok, output popped_value, output found,
                   output head_value, output tail_value, output entry_count,
                   input ready);
   modport sink   (input valid, input ok, input popped_value, input found,
                   input head_value, input tail_value, input entry_count,
                   output ready);
endinterface

// File: design/scf_cell.sv
module scf_cell
   import scf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  chain_ctrl_type ctrl,
   input  logic           prev_live,
   input  logic           next_live,
   input  word_type       next_value,
   output logic           live,
   output word_type       value,
   output logic           hit
);

   logic     live_ff, live_in;
   word_type value_ff, value_in;
   logic     hit_ff, hit_in;
   logic     load;

   // The first free cell behind a live neighbor takes the new item.
   assign load = ctrl.enq && !live_ff && prev_live;

   always_comb begin
      live_in  = live_ff;
      value_in = value_ff;
      hit_in   = hit_ff;
      if (ctrl.step) begin
         hit_in = ctrl.srch && live_ff && (value_ff == ctrl.data);
         if (ctrl.deq) begin
            // advance toward the head
            live_in  = next_live;
            value_in = next_value;
         end else if (load) begin
            live_in  = 1'b1;
            value_in = ctrl.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         live_ff <= live_in;
         hit_ff  <= hit_in;
      end
      value_ff <= value_in;
   end

   assign live  = live_ff;
   assign value = value_ff;
   assign hit   = hit_ff;

endmodule

// File: design/searchable_circular_fifo.sv
// A result passes the s1 register, then the response register, after acceptance.
// Throughput: one item per cycle for every action while the response is taken;
// cells update and compare all live entries on accept; hits reduce as s1 moves.
// Reset (synchronous, active high) empties the queue and drops any pending
// result; stored words are not cleared.
module searchable_circular_fifo
   import scf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic clock,
   input  logic reset,
   scf_req_if.sink   req_chan,
   scf_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   chain_ctrl_type   ctrl;
   logic [DEPTH:0]   live_vec;
   word_type         value_vec [DEPTH+1];
   logic [DEPTH-1:0] hit_vec;

   logic req_fire, s1_move, empty, full, do_enq, do_deq;

   logic [CNT_W-1:0] count_ff, count_in;
   word_type         tail_ff, tail_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_ok_ff;
   word_type         s1_popped_ff, s1_head_ff, s1_tail_ff;
   logic [CNT_W-1:0] s1_count_ff;
   logic             s1_ok_in;
   word_type         s1_popped_in, s1_head_in, s1_tail_in;

   logic             rsp_valid_ff, rsp_ok_ff, rsp_found_ff;
   word_type         rsp_popped_ff, rsp_head_ff, rsp_tail_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   assign s1_move        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign empty  = !live_vec[0];
   assign full   = live_vec[DEPTH-1];
   assign do_enq = req_fire && (req_chan.action == ACT_ENQUEUE) && !full;
   assign do_deq = req_fire && (req_chan.action == ACT_DEQUEUE) && !empty;

   assign ctrl.step = req_fire;
   assign ctrl.enq  = do_enq;
   assign ctrl.deq  = do_deq;
   assign ctrl.srch = req_fire && (req_chan.action == ACT_SEARCH);
   assign ctrl.data = req_chan.data_value;

   // Tail end of the row: nothing live and no data beyond the last cell.
   assign live_vec[DEPTH]  = 1'b0;
   assign value_vec[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic prev_live;
      if (i == 0) begin : g_first
         assign prev_live = 1'b1;
      end else begin : g_rest
         assign prev_live = live_vec[i-1];
      end
      scf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_live  (prev_live),
         .next_live  (live_vec[i+1]),
         .next_value (value_vec[i+1]),
         .live       (live_vec[i]),
         .value      (value_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   always_comb begin
      count_in = count_ff + CNT_W'(do_enq) - CNT_W'(do_deq);
      tail_in  = do_enq ? req_chan.data_value : tail_ff;

      s1_ok_in     = do_enq || do_deq;
      s1_popped_in = do_deq ? value_vec[0] : '0;
      if (count_in == '0) begin
         s1_head_in = EMPTY_WORD;
         s1_tail_in = EMPTY_WORD;
      end else begin
         s1_tail_in = tail_in;
         if (do_deq) begin
            s1_head_in = value_vec[1];
         end else if (do_enq && empty) begin
            s1_head_in = req_chan.data_value;
         end else begin
            s1_head_in = value_vec[0];
         end
      end

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_move) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end

      tail_ff <= tail_in;

      if (req_fire) begin
         s1_ok_ff     <= s1_ok_in;
         s1_popped_ff <= s1_popped_in;
         s1_head_ff   <= s1_head_in;
         s1_tail_ff   <= s1_tail_in;
         s1_count_ff  <= count_in;
      end

      // Hit flags hold until the next item is accepted, so reduce them here.
      if (s1_valid_ff && s1_move) begin
         rsp_ok_ff     <= s1_ok_ff;
         rsp_popped_ff <= s1_popped_ff;
         rsp_found_ff  <= |hit_vec;
         rsp_head_ff   <= s1_head_ff;
         rsp_tail_ff   <= s1_tail_ff;
         rsp_count_ff  <= s1_count_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ok           = rsp_ok_ff;
   assign rsp_chan.popped_value = rsp_popped_ff;
   assign rsp_chan.found        = rsp_found_ff;
   assign rsp_chan.head_value   = rsp_head_ff;
   assign rsp_chan.tail_value   = rsp_tail_ff;
   assign rsp_chan.entry_count  = rsp_count_ff;

endmodule
